[rtl/cmms_pkg.sv]
// ----------------------------------------------------------------------------
// cmms_pkg
// Types, codes and helpers shared by the CIGAR match/mismatch splitter.
// ----------------------------------------------------------------------------
package cmms_pkg;

    typedef logic [2:0]  opcode_t;
    typedef logic [2:0]  kind_t;
    typedef logic [15:0] length_t;
    typedef logic [7:0]  char_t;

    // input operation codes
    localparam opcode_t OP_HARD_CLIP = 3'd0;
    localparam opcode_t OP_SOFT_CLIP = 3'd1;
    localparam opcode_t OP_INSERTION = 3'd2;
    localparam opcode_t OP_DELETION  = 3'd3;
    localparam opcode_t OP_ALIGNED   = 3'd4;

    // output element kinds
    localparam kind_t KIND_SOFT     = 3'd0;
    localparam kind_t KIND_INS      = 3'd1;
    localparam kind_t KIND_DEL      = 3'd2;
    localparam kind_t KIND_MATCH    = 3'd3;
    localparam kind_t KIND_MISMATCH = 3'd4;

    localparam int unsigned MAX_OP_LEN_DEFAULT = 65535;

    // result queue, room for two elements per transaction plus slack
    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        kind_t   element_kind;
        length_t element_length;
        logic    final_result;
    } element_t;

    function automatic char_t to_upper(input char_t c);
        char_t r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7a)
        begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

[rtl/cmms_if.sv]
// ----------------------------------------------------------------------------
// cmms_if
// Valid/ready channels for CIGAR operation items and extended CIGAR elements.
// ----------------------------------------------------------------------------
interface cmms_item_if;
    logic              valid;
    logic              ready;
    cmms_pkg::opcode_t opcode;
    cmms_pkg::length_t op_length;
    cmms_pkg::char_t   read_char;
    cmms_pkg::char_t   ref_char;
    logic              op_end;

    modport source (output valid, opcode, op_length, read_char, ref_char, op_end,
                    input ready);
    modport sink   (input valid, opcode, op_length, read_char, ref_char, op_end,
                    output ready);
endinterface

interface cmms_elem_if;
    logic              valid;
    logic              ready;
    cmms_pkg::kind_t   element_kind;
    cmms_pkg::length_t element_length;
    logic              final_result;

    modport source (output valid, element_kind, element_length, final_result,
                    input ready);
    modport sink   (input valid, element_kind, element_length, final_result,
                    output ready);
endinterface

[rtl/cigar_match_mismatch_splitter_unit.sv]
// ----------------------------------------------------------------------------
// cigar_match_mismatch_splitter_unit
// Rewrites a CIGAR stream into extended form with = and X runs.
// ----------------------------------------------------------------------------
// Takes one item per cycle while ready: whole H/S/I/D operations or single
// aligned bases. Each accepted transaction yields zero, one or two elements,
// computed in the same cycle from the open run register and written to a
// four-entry result queue; an element appears on the output in the cycle
// after acceptance at the earliest. The queue drains one element per cycle
// while the output is ready; the input stays open while at least two queue
// entries are free. Element lengths are capped at min(MAX_OP_LEN, 65535).
module cigar_match_mismatch_splitter_unit #(
    parameter int unsigned MAX_OP_LEN = cmms_pkg::MAX_OP_LEN_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    cmms_item_if.sink  item,
    cmms_elem_if.source elem
);

    localparam cmms_pkg::length_t LEN_LIMIT =
        16'((MAX_OP_LEN > 65535) ? 65535 : MAX_OP_LEN);
    localparam int PTR_W = $clog2(cmms_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(cmms_pkg::FIFO_DEPTH + 1);

    logic              run_mis_reg, run_mis_next;
    cmms_pkg::length_t run_len_reg, run_len_next;

    cmms_pkg::element_t fifo_mem [cmms_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               accept, pop;
    logic               mis, extend;
    logic               e0_valid, e1_valid;
    cmms_pkg::element_t e0, e1, slot0, slot1;
    cmms_pkg::length_t  sat_len;
    logic [1:0]         push_cnt;

    assign accept = item.valid && item.ready;
    assign pop    = elem.valid && elem.ready;

    assign mis = cmms_pkg::to_upper(item.read_char) != cmms_pkg::to_upper(item.ref_char);
    assign extend = (run_len_reg != '0) && (run_mis_reg == mis) && (run_len_reg < LEN_LIMIT);
    assign sat_len = (item.op_length > LEN_LIMIT) ? LEN_LIMIT : item.op_length;

    always_comb
    begin
        run_mis_next = run_mis_reg;
        run_len_next = run_len_reg;
        e0_valid     = 1'b0;
        e1_valid     = 1'b0;
        // first element: the open run being closed
        e0.element_kind   = run_mis_reg ? cmms_pkg::KIND_MISMATCH : cmms_pkg::KIND_MATCH;
        e0.element_length = run_len_reg;
        e0.final_result   = 1'b0;
        e1.element_kind   = cmms_pkg::KIND_DEL;
        e1.element_length = sat_len;
        e1.final_result   = 1'b1;
        if (accept)
        begin
            if (item.opcode == cmms_pkg::OP_ALIGNED)
            begin
                if (extend)
                begin
                    run_len_next = run_len_reg + 16'd1;
                end
                else
                begin
                    e0_valid     = run_len_reg != '0;
                    run_mis_next = mis;
                    run_len_next = 16'd1;
                end
                if (item.op_end)
                begin
                    e1_valid          = 1'b1;
                    e1.element_kind   = run_mis_next ? cmms_pkg::KIND_MISMATCH
                                                     : cmms_pkg::KIND_MATCH;
                    e1.element_length = run_len_next;
                    run_mis_next      = 1'b0;
                    run_len_next      = '0;
                end
            end
            else
            begin
                e0_valid     = run_len_reg != '0;
                run_mis_next = 1'b0;
                run_len_next = '0;
                unique case (item.opcode)
                    cmms_pkg::OP_SOFT_CLIP:
                    begin
                        e1_valid        = item.op_length != '0;
                        e1.element_kind = cmms_pkg::KIND_SOFT;
                    end
                    cmms_pkg::OP_INSERTION:
                    begin
                        e1_valid        = item.op_length != '0;
                        e1.element_kind = cmms_pkg::KIND_INS;
                    end
                    cmms_pkg::OP_DELETION:
                    begin
                        e1_valid        = item.op_length != '0;
                        e1.element_kind = cmms_pkg::KIND_DEL;
                    end
                    default:
                    begin
                        e1_valid = 1'b0;
                    end
                endcase
            end
        end
        e0.final_result = !e1_valid;
    end

    // compact the two candidates into consecutive queue slots
    assign slot0    = e0_valid ? e0 : e1;
    assign slot1    = e1;
    assign push_cnt = {1'b0, e0_valid} + {1'b0, e1_valid};

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= slot0;
        end
        if (push_cnt == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + PTR_W'(1)] <= slot1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_mis_reg <= 1'b0;
            run_len_reg <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            run_mis_reg <= run_mis_next;
            run_len_reg <= run_len_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            count_reg   <= count_next;
        end
    end

    assign item.ready = count_reg <= CNT_W'(cmms_pkg::FIFO_DEPTH - 2);

    assign elem.valid          = count_reg != '0;
    assign elem.element_kind   = fifo_mem[rd_ptr_reg].element_kind;
    assign elem.element_length = fifo_mem[rd_ptr_reg].element_length;
    assign elem.final_result   = fifo_mem[rd_ptr_reg].final_result;

    // queue never overfills
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(cmms_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // the last base of an operation always closes the run
    a_run_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.opcode == cmms_pkg::OP_ALIGNED && item.op_end) |=>
            (run_len_reg == '0))
        else $error("run left open after last aligned base");

    // open run never exceeds the length cap
    a_run_limit: assert property (@(posedge clk) disable iff (!rst_n)
        run_len_reg <= LEN_LIMIT)
        else $error("run length above limit");

    // every delivered element has a nonzero length
    a_elem_len: assert property (@(posedge clk) disable iff (!rst_n)
        elem.valid |-> (elem.element_length != '0))
        else $error("zero-length element emitted");

endmodule
